FILE: sv/wgm_pkg.sv
// shared types and constants of the wildcard glob matcher
package wgm_pkg;

    // default pattern store depth
    localparam int MAX_PATTERN_DEF = 64;

    // field widths
    localparam int SYM_W     = 8;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    // wildcard codes after reset
    localparam logic [SYM_W-1:0] STAR_RESET = 8'd42;
    localparam logic [SYM_W-1:0] ANY_RESET  = 8'd63;

    // item function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PATTERN = 2'd0,
        FUNC_TEXT    = 2'd1,
        FUNC_END     = 2'd2
    } t_func;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STAR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANY  = 1'd1;

endpackage

FILE: sv/wgm_if.sv
// valid/ready channel interfaces for input items and match results

interface wgm_in_if;
    logic                        valid;
    logic                        ready;
    logic [wgm_pkg::FUNC_W-1:0]  func;
    logic [wgm_pkg::SYM_W-1:0]   symbol;
    logic                        first;

    modport source (output valid, output func, output symbol, output first, input ready);
    modport sink   (input valid, input func, input symbol, input first, output ready);
endinterface

interface wgm_out_if;
    logic valid;
    logic ready;
    logic match;
    logic overflow;

    modport source (output valid, output match, output overflow, input ready);
    modport sink   (input valid, input match, input overflow, output ready);
endinterface

FILE: sv/wgm_star_scan.sv
// parallel prefix closure of active positions over runs of stars
module wgm_star_scan #(
    parameter int WIDTH = wgm_pkg::MAX_PATTERN_DEF + 1
) (
    input  logic [WIDTH-1:0] i_gen,
    input  logic [WIDTH-1:0] i_prop,
    output logic [WIDTH-1:0] o_closed
);

    localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] g_lvl [LEVELS+1];
    logic [WIDTH-1:0] p_lvl [LEVELS+1];

    assign g_lvl[0] = i_gen;
    assign p_lvl[0] = i_prop;

    // kogge-stone levels: position i is set if some earlier set position
    // reaches it through an unbroken chain of star propagates
    for (genvar l = 0; l < LEVELS; l++) begin : g_level
        localparam int DIST = 1 << l;
        for (genvar i = 0; i < WIDTH; i++) begin : g_bit
            if (i >= DIST) begin : g_comb
                assign g_lvl[l+1][i] = g_lvl[l][i] | (p_lvl[l][i] & g_lvl[l][i-DIST]);
                assign p_lvl[l+1][i] = p_lvl[l][i] & p_lvl[l][i-DIST];
            end else begin : g_pass
                assign g_lvl[l+1][i] = g_lvl[l][i];
                assign p_lvl[l+1][i] = p_lvl[l][i];
            end
        end
    end

    assign o_closed = g_lvl[LEVELS];

endmodule

FILE: sv/wildcard_glob_matcher_top.sv
// Glob matcher: pattern characters are written into a register row one per
// transaction; text characters then advance a vector with one bit per pattern
// prefix, all bits in parallel, and an end transaction returns match and
// overflow. A new transaction is accepted each cycle unless an end transaction
// waits for a held result; its result passes the input register and then the
// result register. The cycle is set by the star closure, a prefix scan over
// MAX_PATTERN+1 positions with log2 depth, followed by one character compare
// per position. The store has no clearing pass and is ready right after reset.
module wildcard_glob_matcher_top #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wgm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wgm_pkg::CFG_W-1:0]      i_cfg_data,
    wgm_in_if.sink                         i_in,
    wgm_out_if.source                      o_out
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int VEC_W = MAX_PATTERN + 1;
    localparam logic [VEC_W-1:0] START_VEC = VEC_W'(1);

    // configuration registers
    logic [wgm_pkg::SYM_W-1:0] r_star;
    logic [wgm_pkg::SYM_W-1:0] r_any;

    // input register
    logic                       r_in_valid;
    logic [wgm_pkg::FUNC_W-1:0] r_func;
    logic [wgm_pkg::SYM_W-1:0]  r_sym;
    logic                       r_first;

    // matcher state
    logic [wgm_pkg::SYM_W-1:0] r_store [MAX_PATTERN];
    logic [LEN_W-1:0]          r_len;
    logic [VEC_W-1:0]          r_act;
    logic                      r_ovf;

    // result register
    logic r_out_valid;
    logic r_out_match;
    logic r_out_ovf;

    logic             in_fire;
    logic             stage_adv;
    logic             stage_fire;
    logic [VEC_W-1:0] base_vec;
    logic [VEC_W-1:0] prop_vec;
    logic [VEC_W-1:0] closed_vec;
    logic [VEC_W-1:0] step_vec;
    logic [MAX_PATTERN-1:0] is_star;
    logic [MAX_PATTERN-1:0] is_lit;
    logic [LEN_W-1:0] len_base;
    logic             store_we;
    logic             out_load;
    logic             hit;
    logic [LEN_W-1:0] n_len;
    logic [VEC_W-1:0] n_act;
    logic             n_ovf;

    // handshakes; an end transaction waits only when the result register is held
    assign stage_adv  = !r_out_valid || o_out.ready || (r_func != wgm_pkg::FUNC_END);
    assign stage_fire = r_in_valid && stage_adv;
    assign i_in.ready = i_rst_n && (!r_in_valid || stage_adv);
    assign in_fire    = i_in.valid && i_in.ready;

    // per position decode of stored pattern characters, star wins over any
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            is_star[i] = (LEN_W'(i) < r_len) && (r_store[i] == r_star);
            is_lit[i]  = (LEN_W'(i) < r_len) && (r_store[i] != r_star)
                         && ((r_store[i] == r_any) || (r_store[i] == r_sym));
        end
    end

    // text start restarts from position zero
    assign base_vec = ((r_func == wgm_pkg::FUNC_TEXT) && r_first) ? START_VEC : r_act;
    assign prop_vec = {is_star, 1'b0};

    wgm_star_scan #(
        .WIDTH (VEC_W)
    ) u_scan (
        .i_gen    (base_vec),
        .i_prop   (prop_vec),
        .o_closed (closed_vec)
    );

    // one text character step: stars hold, literals and any advance
    always_comb begin
        step_vec = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            step_vec[i]   = step_vec[i] | (closed_vec[i] & is_star[i]);
            step_vec[i+1] = step_vec[i+1] | (closed_vec[i] & is_lit[i]);
        end
    end

    assign hit      = closed_vec[r_len] && !r_ovf;
    assign len_base = r_first ? '0 : r_len;

    // state update decode
    always_comb begin
        n_len    = r_len;
        n_act    = r_act;
        n_ovf    = r_ovf;
        store_we = 1'b0;
        out_load = 1'b0;
        unique case (r_func)
            wgm_pkg::FUNC_PATTERN: begin
                n_act = START_VEC;
                if (len_base < LEN_W'(MAX_PATTERN)) begin
                    store_we = 1'b1;
                    n_len    = len_base + LEN_W'(1);
                    n_ovf    = r_first ? 1'b0 : r_ovf;
                end else begin
                    n_len = len_base;
                    n_ovf = 1'b1;
                end
            end
            wgm_pkg::FUNC_TEXT: begin
                n_act = step_vec;
            end
            wgm_pkg::FUNC_END: begin
                n_act    = START_VEC;
                out_load = 1'b1;
            end
            default: begin
                n_act = r_act;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_star      <= wgm_pkg::STAR_RESET;
            r_any       <= wgm_pkg::ANY_RESET;
            r_in_valid  <= 1'b0;
            r_len       <= '0;
            r_act       <= START_VEC;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    wgm_pkg::CFG_STAR: r_star <= i_cfg_data;
                    wgm_pkg::CFG_ANY:  r_any  <= i_cfg_data;
                    default:           r_star <= r_star;
                endcase
            end
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (stage_fire) begin
                r_in_valid <= 1'b0;
            end
            if (stage_fire) begin
                r_len <= n_len;
                r_act <= n_act;
                r_ovf <= n_ovf;
            end
            if (stage_fire && out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func  <= i_in.func;
            r_sym   <= i_in.symbol;
            r_first <= i_in.first;
        end
        if (stage_fire && out_load) begin
            r_out_match <= hit;
            r_out_ovf   <= r_ovf;
        end
    end

    // pattern register row, written at the fill position
    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_store
        always_ff @(posedge i_clk) begin
            if (stage_fire && store_we && (len_base == LEN_W'(i))) begin
                r_store[i] <= r_sym;
            end
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.match    = r_out_match;
    assign o_out.overflow = r_out_ovf;

endmodule

FILE: sv/wgm_checker.sv
// port level checks of the glob matcher and their binding
module wgm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic [wgm_pkg::FUNC_W-1:0] i_in_func,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_out_match,
    input logic                       i_out_overflow
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a held result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_match) && $stable(i_out_overflow))
        else $error("result payload changed while stalled");

    // overflow forces a miss
    a_ovf_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_match && i_out_overflow))
        else $error("match reported with overflow");

    // a fresh result traces back to an accepted end transaction
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |->
            $past(i_in_valid && i_in_ready && (i_in_func == wgm_pkg::FUNC_END), 2))
        else $error("result without end transaction");

endmodule

bind wildcard_glob_matcher_top wgm_checker u_wgm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_func      (i_in.func),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_match    (o_out.match),
    .i_out_overflow (o_out.overflow)
);

FILE: tb/wildcard_glob_matcher_top_tb.sv
// self-checking testbench for the wildcard glob matcher: directed table, then random sequences
module wildcard_glob_matcher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PATTERN     = wgm_pkg::MAX_PATTERN_DEF;
    localparam int SETTLE_CYCLES   = 6;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_QUOTA    = 280;
    localparam int PRESSURE_AT     = 30;
    localparam int PRESSURE_CYCLES = 200;
    localparam int REPORT_MAX      = 10;

    // func code the block must ignore
    localparam logic [wgm_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic [wgm_pkg::SYM_W-1:0] SYM_A     = 8'h61;
    localparam logic [MAX_PATTERN:0]      START_POS = (MAX_PATTERN + 1)'(1);

    typedef struct packed {
        logic match;
        logic overflow;
    } t_verdict;

    typedef struct packed {
        logic [wgm_pkg::FUNC_W-1:0] func;
        logic [wgm_pkg::SYM_W-1:0]  sym;
        logic                       first;
        logic                       fixed;
        logic                       exp_match;
        logic                       exp_overflow;
    } t_row;

    // directed transactions; the expected result is typed in where it is obvious
    localparam int N_ROWS = 26;
    localparam t_row DIRECTED [N_ROWS] = '{
        // empty pattern against empty text, then against a one-character text
        '{wgm_pkg::FUNC_END,     8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
        '{wgm_pkg::FUNC_TEXT,    8'h61, 1'b1, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_END,     8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
        // unused func is ignored
        '{FUNC_UNUSED,           8'hff, 1'b1, 1'b0, 1'b0, 1'b0},
        // "a*?" against "axy"
        '{wgm_pkg::FUNC_PATTERN, 8'h61, 1'b1, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_PATTERN, 8'h2a, 1'b0, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_PATTERN, 8'h3f, 1'b0, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_TEXT,    8'h61, 1'b1, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_TEXT,    8'h78, 1'b0, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_TEXT,    8'h79, 1'b0, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_END,     8'hff, 1'b1, 1'b0, 1'b0, 1'b0},
        // star pattern against a literal star in the text
        '{wgm_pkg::FUNC_PATTERN, 8'h2a, 1'b1, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_TEXT,    8'h2a, 1'b1, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_END,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        // symbol extremes
        '{wgm_pkg::FUNC_PATTERN, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_PATTERN, 8'hff, 1'b0, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_TEXT,    8'h00, 1'b1, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_TEXT,    8'hff, 1'b0, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_END,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        // pattern character in the middle of a text abandons that text
        '{wgm_pkg::FUNC_PATTERN, 8'h62, 1'b1, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_TEXT,    8'h62, 1'b1, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_PATTERN, 8'h63, 1'b0, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_TEXT,    8'h62, 1'b0, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_TEXT,    8'h63, 1'b0, 1'b0, 1'b0, 1'b0},
        '{wgm_pkg::FUNC_END,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        // end right after end: empty text against a non-empty pattern
        '{wgm_pkg::FUNC_END,     8'h00, 1'b0, 1'b1, 1'b0, 1'b0}
    };

    // wildcard code settings walked after the first phase
    localparam int N_PHASES = 3;
    localparam logic [wgm_pkg::SYM_W-1:0] PHASE_CODES [N_PHASES][2] = '{
        '{8'd0,   8'd255},
        '{8'd255, 8'd0},
        '{8'd97,  8'd97}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [wgm_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [wgm_pkg::CFG_W-1:0]     cfg_data;

    wgm_in_if  in_ch ();
    wgm_out_if out_ch ();

    wildcard_glob_matcher_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #2 clk = ~clk;

    // matcher state as the testbench sees it
    logic [wgm_pkg::SYM_W-1:0] pat_mem [MAX_PATTERN];
    int                        pat_len;
    logic [MAX_PATTERN:0]      live_pos;
    logic                      pat_overflow;
    logic [wgm_pkg::SYM_W-1:0] star_sym;
    logic [wgm_pkg::SYM_W-1:0] any_sym;

    t_verdict verdict_q [$];
    int  mismatch_cnt = 0;
    int  n_items = 0;
    int  n_checked = 0;
    int  cycle_cnt = 0;
    bit  calm_send = 1'b0;
    bit  calm_recv = 1'b0;
    bit  pressure_done = 1'b0;

    // run guard
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
                     verdict_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // every active star position also activates the position after it
    function automatic logic [MAX_PATTERN:0] star_closure(input logic [MAX_PATTERN:0] v);
        for (int i = 0; i < pat_len; i++) begin
            if (v[i] && pat_mem[i] == star_sym) v[i+1] = 1'b1;
        end
        return v;
    endfunction

    // advance the matcher state by one transaction; returns 1 when a result is due
    function automatic bit glob_step(input logic [wgm_pkg::FUNC_W-1:0] f,
                                     input logic [wgm_pkg::SYM_W-1:0] s,
                                     input logic fst, output t_verdict v);
        logic [MAX_PATTERN:0] cl;
        logic [MAX_PATTERN:0] nx;
        bit emitted;
        emitted = 1'b0;
        v = '0;
        case (f)
            wgm_pkg::FUNC_PATTERN: begin
                if (fst) begin
                    pat_len = 0;
                    pat_overflow = 1'b0;
                end
                if (pat_len < MAX_PATTERN) begin
                    pat_mem[pat_len] = s;
                    pat_len++;
                end else begin
                    pat_overflow = 1'b1;
                end
                live_pos = START_POS;
            end
            wgm_pkg::FUNC_TEXT: begin
                if (fst) live_pos = START_POS;
                cl = star_closure(live_pos);
                nx = '0;
                for (int i = 0; i < pat_len; i++) begin
                    if (cl[i]) begin
                        if (pat_mem[i] == star_sym) nx[i] = 1'b1;
                        else if (pat_mem[i] == any_sym || pat_mem[i] == s) nx[i+1] = 1'b1;
                    end
                end
                live_pos = nx;
            end
            wgm_pkg::FUNC_END: begin
                cl = star_closure(live_pos);
                v.overflow = pat_overflow;
                v.match = cl[pat_len] && !pat_overflow;
                live_pos = START_POS;
                emitted = 1'b1;
            end
            default: ;
        endcase
        return emitted;
    endfunction

    // offer one transaction after a random gap and log its expected result on acceptance
    task automatic put_item(input logic [wgm_pkg::FUNC_W-1:0] f,
                            input logic [wgm_pkg::SYM_W-1:0] s,
                            input logic fst, input logic fixed = 1'b0,
                            input logic fix_match = 1'b0, input logic fix_ovf = 1'b0);
        int gap;
        t_verdict v;
        if ($urandom_range(0, 39) == 0) calm_send = !calm_send;
        gap = calm_send ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.func   <= f;
        in_ch.symbol <= s;
        in_ch.first  <= fst;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        if (glob_step(f, s, fst, v)) begin
            if (fixed) begin
                v.match = fix_match;
                v.overflow = fix_ovf;
            end
            verdict_q.push_back(v);
        end
        if (f != FUNC_UNUSED) n_items++;
    endtask

    // text characters: mostly a small alphabet, sometimes a wildcard code or any byte
    function automatic logic [wgm_pkg::SYM_W-1:0] text_sym();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return wgm_pkg::SYM_W'($urandom_range(0, 255));
        if (r == 1) return star_sym;
        if (r == 2) return any_sym;
        return SYM_A + wgm_pkg::SYM_W'($urandom_range(0, 2));
    endfunction

    function automatic logic [wgm_pkg::SYM_W-1:0] pattern_sym();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return star_sym;
        if (r < 4) return any_sym;
        if (r < 9) return text_sym();
        return wgm_pkg::SYM_W'($urandom_range(0, 255));
    endfunction

    // one pattern followed by a few texts, each closed by an end transaction
    task automatic send_sequence();
        logic [wgm_pkg::SYM_W-1:0] pat [$];
        logic [wgm_pkg::SYM_W-1:0] txt [$];
        int len;
        int n_texts;
        if ($urandom_range(0, 24) == 0) len = $urandom_range(62, 68);
        else len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) pat.push_back(pattern_sym());
        for (int i = 0; i < len; i++) put_item(wgm_pkg::FUNC_PATTERN, pat[i], i == 0);
        n_texts = $urandom_range(1, 3);
        for (int t = 0; t < n_texts; t++) begin
            txt.delete();
            if ($urandom_range(0, 1) == 0) begin
                // text built to fit the pattern, sometimes with one character spoiled
                foreach (pat[i]) begin
                    if (pat[i] == star_sym) begin
                        repeat ($urandom_range(0, 3)) txt.push_back(text_sym());
                    end else if (pat[i] == any_sym) begin
                        txt.push_back(text_sym());
                    end else begin
                        txt.push_back(pat[i]);
                    end
                end
                if (txt.size() > 0 && $urandom_range(0, 3) == 0)
                    txt[$urandom_range(0, txt.size() - 1)] = text_sym();
            end else begin
                repeat ($urandom_range(0, 10)) txt.push_back(text_sym());
            end
            foreach (txt[j])
                put_item(wgm_pkg::FUNC_TEXT, txt[j],
                         (j == 0) ? ($urandom_range(0, 4) != 0) : 1'b0);
            put_item(wgm_pkg::FUNC_END, wgm_pkg::SYM_W'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
        end
    endtask

    // stray and broken transactions
    task automatic send_noise();
        case ($urandom_range(0, 4))
            0: put_item(FUNC_UNUSED, wgm_pkg::SYM_W'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
            1: put_item(wgm_pkg::FUNC_END, wgm_pkg::SYM_W'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
            2: put_item(wgm_pkg::FUNC_PATTERN, pattern_sym(), 1'b0);
            3: put_item(wgm_pkg::FUNC_TEXT, wgm_pkg::SYM_W'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
            default: begin
                put_item(wgm_pkg::FUNC_TEXT, text_sym(), 1'b1);
                put_item(wgm_pkg::FUNC_TEXT, text_sym(), 1'b0);
                put_item(wgm_pkg::FUNC_PATTERN, pattern_sym(), 1'($urandom_range(0, 1)));
                put_item(wgm_pkg::FUNC_TEXT, text_sym(), 1'b0);
                put_item(wgm_pkg::FUNC_END, 8'h00, 1'b0);
            end
        endcase
    endtask

    task automatic run_random(input int quota);
        int stop;
        stop = n_items + quota;
        while (n_items < stop) begin
            if ($urandom_range(0, 9) < 8) send_sequence();
            else send_noise();
        end
    endtask

    // let every result drain, then give text transactions in flight time to settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_codes(input logic [wgm_pkg::SYM_W-1:0] star_val,
                             input logic [wgm_pkg::SYM_W-1:0] any_val);
        cfg_we   <= 1'b1;
        cfg_idx  <= wgm_pkg::CFG_STAR;
        cfg_data <= star_val;
        @(posedge clk);
        cfg_idx  <= wgm_pkg::CFG_ANY;
        cfg_data <= any_val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        star_sym = star_val;
        any_sym  = any_val;
    endtask

    task automatic check_result(input logic m, input logic o);
        t_verdict want;
        n_checked++;
        if (verdict_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
                $display("result %0d arrived with nothing expected: match=%b overflow=%b",
                         n_checked, m, o);
        end else begin
            want = verdict_q.pop_front();
            if (m !== want.match || o !== want.overflow) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("result %0d: expected match=%b overflow=%b, got match=%b overflow=%b",
                             n_checked, want.match, want.overflow, m, o);
            end
        end
    endtask

    // result side: random stalls, one long hold-off so the block backs up
    initial begin : result_sink
        int hold;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0) calm_recv = !calm_recv;
            hold = calm_recv ? 0 : $urandom_range(0, 4);
            if (n_checked == PRESSURE_AT && !pressure_done) begin
                hold = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (out_ch.valid !== 1'b1) @(posedge clk);
            check_result(out_ch.match, out_ch.overflow);
        end
    end

    // stimulus
    initial begin : stimulus
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= wgm_pkg::CFG_STAR;
        cfg_data     <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.func   <= wgm_pkg::FUNC_PATTERN;
        in_ch.symbol <= '0;
        in_ch.first  <= 1'b0;
        star_sym     = wgm_pkg::STAR_RESET;
        any_sym      = wgm_pkg::ANY_RESET;
        pat_len      = 0;
        pat_overflow = 1'b0;
        live_pos     = START_POS;
        foreach (pat_mem[i]) pat_mem[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < N_ROWS; k++)
            put_item(DIRECTED[k].func, DIRECTED[k].sym, DIRECTED[k].first, DIRECTED[k].fixed,
                     DIRECTED[k].exp_match, DIRECTED[k].exp_overflow);
        run_random(RANDOM_QUOTA);

        // fixed code settings, then a random one, then back to the reset codes
        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            set_codes(PHASE_CODES[p][0], PHASE_CODES[p][1]);
            run_random(RANDOM_QUOTA);
        end
        drain();
        set_codes(wgm_pkg::SYM_W'($urandom_range(0, 255)),
                  wgm_pkg::SYM_W'($urandom_range(0, 255)));
        run_random(RANDOM_QUOTA);
        drain();
        set_codes(wgm_pkg::STAR_RESET, wgm_pkg::ANY_RESET);
        run_random(RANDOM_QUOTA);

        drain();
        if (mismatch_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/wgm_pkg.sv
sv/wgm_if.sv
sv/wgm_star_scan.sv
sv/wildcard_glob_matcher_top.sv
sv/wgm_checker.sv
tb/wildcard_glob_matcher_top_tb.sv
